FILE: rtl/fsa_pkg.sv
// Package for the FIFO swap allocator: sizes, status and register codes,
// microcode encoding, the control-store program and the structs between modules.
// No dependencies.
package fsa_pkg;

    // Table and field sizes.
    localparam int ID_COUNT  = 256;
    localparam int ID_W      = $clog2(ID_COUNT);
    localparam int FILL_W    = ID_W + 1;
    localparam int SIZE_BITS = 16;
    localparam int REQ_W     = SIZE_BITS + 1;
    localparam int VSHARE_W  = SIZE_BITS + 1;
    localparam int VUSED_W   = SIZE_BITS + 2;
    localparam int EVICT_W   = ID_W + 1;

    localparam logic [VSHARE_W-1:0] VSHARE_MAX = '1;
    localparam logic [VUSED_W-1:0]  VUSED_MAX  = '1;

    // Result status codes.
    localparam logic [1:0] ST_PLACED    = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_HELD      = 2'd2;
    localparam logic [1:0] ST_UNUSED    = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_RAM_CAP  = 1'b0;
    localparam logic CFG_VIRT_CAP = 1'b1;

    // Datapath operations of a control word.
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_ACCEPT   = 4'd1;
    localparam logic [3:0] OP_CHECK    = 4'd2;
    localparam logic [3:0] OP_POP      = 4'd3;
    localparam logic [3:0] OP_TAKE     = 4'd4;
    localparam logic [3:0] OP_EVICT    = 4'd5;
    localparam logic [3:0] OP_SPLIT    = 4'd6;
    localparam logic [3:0] OP_PUT_RAM  = 4'd7;
    localparam logic [3:0] OP_PUT_VIRT = 4'd8;
    localparam logic [3:0] OP_EMIT     = 4'd9;

    // Jump conditions of a control word.
    localparam logic [2:0] COND_NEVER        = 3'd0;
    localparam logic [2:0] COND_ALWAYS       = 3'd1;
    localparam logic [2:0] COND_NO_INPUT     = 3'd2;
    localparam logic [2:0] COND_REFUSED      = 3'd3;
    localparam logic [2:0] COND_FITS         = 3'd4;
    localparam logic [2:0] COND_NOT_RESIDENT = 3'd5;
    localparam logic [2:0] COND_OUT_BUSY     = 3'd6;

    // Program step addresses.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] S_CHECK    = 4'd1;
    localparam logic [STEP_W-1:0] S_TEST     = 4'd2;
    localparam logic [STEP_W-1:0] S_POP      = 4'd3;
    localparam logic [STEP_W-1:0] S_TAKE     = 4'd4;
    localparam logic [STEP_W-1:0] S_EVICT    = 4'd5;
    localparam logic [STEP_W-1:0] S_SPLIT    = 4'd6;
    localparam logic [STEP_W-1:0] S_PUT_RAM  = 4'd7;
    localparam logic [STEP_W-1:0] S_PUT_VIRT = 4'd8;
    localparam logic [STEP_W-1:0] S_EMIT     = 4'd9;
    localparam logic [STEP_W-1:0] S_RETURN   = 4'd10;

    typedef struct packed {
        logic [3:0]        op;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    // Condition inputs of the sequencer.
    typedef struct packed {
        logic no_input;
        logic refused;
        logic fits;
        logic not_resident;
        logic out_busy;
    } t_flags;

    // Conditions produced by the datapath.
    typedef struct packed {
        logic refused;
        logic fits;
        logic not_resident;
    } t_dp_flags;

    typedef struct packed {
        logic [1:0]           status;
        logic [SIZE_BITS-1:0] ram_granted;
        logic [VSHARE_W-1:0]  virtual_granted;
        logic [EVICT_W-1:0]   evicted_count;
        logic [SIZE_BITS-1:0] ram_in_use;
        logic [VUSED_W-1:0]   virtual_in_use;
        logic                 virtual_overcommit;
    } t_result;

    // Control store. A word jumps to target when its condition holds,
    // and otherwise steps to the next address.
    function automatic t_ctrl rom_word(input logic [STEP_W-1:0] step);
        t_ctrl w;
        unique case (step)
            S_IDLE:     w = '{op: OP_ACCEPT,   cond: COND_NO_INPUT,     target: S_IDLE};
            S_CHECK:    w = '{op: OP_CHECK,    cond: COND_REFUSED,      target: S_EMIT};
            S_TEST:     w = '{op: OP_NONE,     cond: COND_FITS,         target: S_SPLIT};
            S_POP:      w = '{op: OP_POP,      cond: COND_NEVER,        target: S_IDLE};
            S_TAKE:     w = '{op: OP_TAKE,     cond: COND_NOT_RESIDENT, target: S_TEST};
            S_EVICT:    w = '{op: OP_EVICT,    cond: COND_ALWAYS,       target: S_TEST};
            S_SPLIT:    w = '{op: OP_SPLIT,    cond: COND_NEVER,        target: S_IDLE};
            S_PUT_RAM:  w = '{op: OP_PUT_RAM,  cond: COND_NEVER,        target: S_IDLE};
            S_PUT_VIRT: w = '{op: OP_PUT_VIRT, cond: COND_NEVER,        target: S_IDLE};
            S_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_BUSY,     target: S_EMIT};
            S_RETURN:   w = '{op: OP_NONE,     cond: COND_ALWAYS,       target: S_IDLE};
            default:    w = '{op: OP_NONE,     cond: COND_ALWAYS,       target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/fifo_swap_allocator.sv
// Top level of the FIFO swap allocator: handshakes, output register and the
// sequencer and datapath instances. Depends on fsa_pkg, fsa_seq and fsa_dpath.
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+---------------------------------
//   request  | in        | i_in_valid / o_in_ready      | i_proc_id, i_req_size
//   result   | out       | o_out_valid / i_out_ready    | o_status .. o_virtual_overcommit
//   config   | in        | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// A placed request steps through check, test, split, both puts, emit and return; a refused one
// goes from check to emit. Each FIFO entry popped adds a pop, take and test step (and an evict
// step if it still holds RAM), all set by the microcode stepping through one shared datapath.
// Synchronous active-low reset clears the capacities, counters, pointers and valid
// bits. A result waiting in the output register does not block the
// next request; the program stalls on its emit step only while it is still held.
module fifo_swap_allocator
    import fsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [ID_W-1:0]      i_proc_id,
    input  logic [REQ_W-1:0]     i_req_size,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [SIZE_BITS-1:0] o_ram_granted,
    output logic [VSHARE_W-1:0]  o_virtual_granted,
    output logic [EVICT_W-1:0]   o_evicted_count,
    output logic [SIZE_BITS-1:0] o_ram_in_use,
    output logic [VUSED_W-1:0]   o_virtual_in_use,
    output logic                 o_virtual_overcommit,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [SIZE_BITS-1:0] i_cfg_data
);

    t_ctrl     w_ctrl;
    t_flags    w_flags;
    t_dp_flags w_dp_flags;
    t_result   w_result;
    t_result   r_out;
    logic      r_out_valid;
    logic      w_accept;
    logic      w_out_busy;
    logic      w_emit;

    // Handshake decode. No request is taken while reset is held.
    assign o_in_ready = i_rst_n && (w_ctrl.op == OP_ACCEPT);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_busy = r_out_valid && !i_out_ready;
    assign w_emit     = (w_ctrl.op == OP_EMIT) && !w_out_busy;

    assign w_flags.no_input     = !i_in_valid;
    assign w_flags.refused      = w_dp_flags.refused;
    assign w_flags.fits         = w_dp_flags.fits;
    assign w_flags.not_resident = w_dp_flags.not_resident;
    assign w_flags.out_busy     = w_out_busy;

    fsa_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    fsa_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_accept   (w_accept),
        .i_proc_id  (i_proc_id),
        .i_req_size (i_req_size),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_flags    (w_dp_flags),
        .o_result   (w_result)
    );

    // Output register: loaded on the emit step, released by a result transfer.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out.status;
    assign o_ram_granted        = r_out.ram_granted;
    assign o_virtual_granted    = r_out.virtual_granted;
    assign o_evicted_count      = r_out.evicted_count;
    assign o_ram_in_use         = r_out.ram_in_use;
    assign o_virtual_in_use     = r_out.virtual_in_use;
    assign o_virtual_overcommit = r_out.virtual_overcommit;

    // After a request transfer the program has left its accept step.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("request accepted while another is in progress");

    // A refused request grants nothing and evicts nothing.
    a_refused_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_PLACED)) |->
            (r_out.ram_granted == '0) && (r_out.virtual_granted == '0)
            && (r_out.evicted_count == '0))
        else $error("refused request carries grants or evictions");

    // Only the three defined status codes are produced.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.status != ST_UNUSED))
        else $error("undefined status code in result");

    // A result is never loaded over one that is still held.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_busy |=> $stable(r_out))
        else $error("held result overwritten");

endmodule

FILE: rtl/fsa_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module fsa_ram #(
    parameter int P_WIDTH  = 8,
    parameter int P_ADDR_W = 8
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [P_ADDR_W-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]  i_wdata,
    input  logic [P_ADDR_W-1:0] i_raddr,
    output logic [P_WIDTH-1:0]  o_rdata
);

    logic [P_WIDTH-1:0] r_mem [2**P_ADDR_W];
    logic [P_WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fsa_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on fsa_pkg.
module fsa_seq
    import fsa_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl
);

    logic [STEP_W-1:0] r_pc;
    logic [STEP_W-1:0] n_pc;
    t_ctrl             w_word;
    logic              w_jump;

    assign w_word = rom_word(r_pc);

    // Select the jump condition named by the current word.
    always_comb begin
        unique case (w_word.cond)
            COND_NEVER:        w_jump = 1'b0;
            COND_ALWAYS:       w_jump = 1'b1;
            COND_NO_INPUT:     w_jump = i_flags.no_input;
            COND_REFUSED:      w_jump = i_flags.refused;
            COND_FITS:         w_jump = i_flags.fits;
            COND_NOT_RESIDENT: w_jump = i_flags.not_resident;
            COND_OUT_BUSY:     w_jump = i_flags.out_busy;
            default:           w_jump = 1'b1;
        endcase
        n_pc = w_jump ? w_word.target : r_pc + 1'b1;
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = w_word;

endmodule

FILE: rtl/fsa_dpath.sv
// Allocator datapath: capacity registers, usage counters, age FIFO pointers,
// valid bits and the share and FIFO memories, all driven by control words.
// Depends on fsa_pkg and fsa_ram.
module fsa_dpath
    import fsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl                i_ctrl,
    input  logic                 i_accept,
    input  logic [ID_W-1:0]      i_proc_id,
    input  logic [REQ_W-1:0]     i_req_size,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [SIZE_BITS-1:0] i_cfg_data,
    output t_dp_flags            o_flags,
    output t_result              o_result
);

    // Request and per-request results.
    logic [ID_W-1:0]      r_id;
    logic [REQ_W-1:0]     r_size;
    logic [1:0]           r_status;
    logic [SIZE_BITS-1:0] r_ram_part;
    logic [VSHARE_W-1:0]  r_virt_part;
    logic [EVICT_W-1:0]   r_evicted;
    logic [ID_W-1:0]      r_old;

    // Persistent state.
    logic [SIZE_BITS-1:0] r_ram_cap;
    logic [SIZE_BITS-1:0] r_virt_cap;
    logic [SIZE_BITS-1:0] r_ram_used;
    logic [VUSED_W-1:0]   r_virt_used;
    logic [ID_W-1:0]      r_head;
    logic [ID_W-1:0]      r_tail;
    logic [FILL_W-1:0]    r_fill;
    logic [ID_COUNT-1:0]  r_ram_vld;
    logic [ID_COUNT-1:0]  r_virt_vld;

    // Memory ports.
    logic [ID_W-1:0]      w_fifo_q;
    logic [SIZE_BITS-1:0] w_rsh_q;
    logic [VSHARE_W-1:0]  w_vsh_q;
    logic                 w_rsh_we;
    logic                 w_vsh_we;
    logic                 w_fifo_we;
    logic [ID_W-1:0]      w_vsh_waddr;
    logic [VSHARE_W-1:0]  w_vsh_wdata;

    // Arithmetic.
    logic [REQ_W-1:0]     w_cap_sum;
    logic [REQ_W:0]       w_need;
    logic                 w_fill_empty;
    logic                 w_fill_full;
    logic [SIZE_BITS-1:0] w_room;
    logic [SIZE_BITS-1:0] w_ram_take;
    logic [SIZE_BITS-1:0] w_used_sub;
    logic [VSHARE_W-1:0]  w_vbase;
    logic [VSHARE_W:0]    w_vshare_sum;
    logic [VSHARE_W-1:0]  w_vshare_new;
    logic [VSHARE_W-1:0]  w_vadd_units;
    logic [VUSED_W:0]     w_vused_sum;
    logic [VUSED_W-1:0]   w_vused_new;
    logic                 w_evict;
    logic                 w_place_ram;
    logic                 w_place_virt;

    // Admission tests and the eviction loop condition.
    assign w_cap_sum    = {1'b0, r_ram_cap} + {1'b0, r_virt_cap};
    assign w_need       = {2'b00, r_ram_used} + {1'b0, r_size};
    assign w_fill_empty = (r_fill == '0);
    assign w_fill_full  = (r_fill == FILL_W'(ID_COUNT));

    assign o_flags.refused      = (r_size > w_cap_sum) || r_ram_vld[r_id] || r_virt_vld[r_id];
    assign o_flags.fits         = (w_need <= {2'b00, r_ram_cap}) || w_fill_empty;
    assign o_flags.not_resident = !r_ram_vld[w_fifo_q];

    // Split of the request between free RAM and virtual memory.
    assign w_room     = (r_ram_cap > r_ram_used) ? r_ram_cap - r_ram_used : '0;
    assign w_ram_take = (r_size < {1'b0, w_room}) ? r_size[SIZE_BITS-1:0] : w_room;

    // Moving an evicted share to virtual memory, adding to any share it holds there.
    assign w_used_sub   = (r_ram_used >= w_rsh_q) ? r_ram_used - w_rsh_q : '0;
    assign w_vbase      = r_virt_vld[r_old] ? w_vsh_q : '0;
    assign w_vshare_sum = {1'b0, w_vbase} + {2'b00, w_rsh_q};
    assign w_vshare_new = w_vshare_sum[VSHARE_W] ? VSHARE_MAX : w_vshare_sum[VSHARE_W-1:0];

    // One saturating adder for virtual use, shared by eviction and placement.
    assign w_evict      = (i_ctrl.op == OP_EVICT);
    assign w_vadd_units = w_evict ? {1'b0, w_rsh_q} : r_virt_part;
    assign w_vused_sum  = {1'b0, r_virt_used} + {2'b00, w_vadd_units};
    assign w_vused_new  = w_vused_sum[VUSED_W] ? VUSED_MAX : w_vused_sum[VUSED_W-1:0];

    assign w_place_ram  = (i_ctrl.op == OP_PUT_RAM) && (r_ram_part != '0);
    assign w_place_virt = (i_ctrl.op == OP_PUT_VIRT) && (r_virt_part != '0);

    // Memory write controls.
    assign w_rsh_we    = w_place_ram;
    assign w_fifo_we   = w_place_ram && !w_fill_full;
    assign w_vsh_we    = w_evict || w_place_virt;
    assign w_vsh_waddr = w_evict ? r_old : r_id;
    assign w_vsh_wdata = w_evict ? w_vshare_new : r_virt_part;

    fsa_ram #(.P_WIDTH(ID_W), .P_ADDR_W(ID_W)) u_fifo_mem (
        .i_clk   (i_clk),
        .i_we    (w_fifo_we),
        .i_waddr (r_tail),
        .i_wdata (r_id),
        .i_raddr (r_head),
        .o_rdata (w_fifo_q)
    );

    fsa_ram #(.P_WIDTH(SIZE_BITS), .P_ADDR_W(ID_W)) u_ram_share (
        .i_clk   (i_clk),
        .i_we    (w_rsh_we),
        .i_waddr (r_id),
        .i_wdata (r_ram_part),
        .i_raddr (w_fifo_q),
        .o_rdata (w_rsh_q)
    );

    fsa_ram #(.P_WIDTH(VSHARE_W), .P_ADDR_W(ID_W)) u_virt_share (
        .i_clk   (i_clk),
        .i_we    (w_vsh_we),
        .i_waddr (w_vsh_waddr),
        .i_wdata (w_vsh_wdata),
        .i_raddr (w_fifo_q),
        .o_rdata (w_vsh_q)
    );

    // Request registers and per-request results.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_id        <= i_proc_id;
            r_size      <= i_req_size;
            r_status    <= ST_PLACED;
            r_ram_part  <= '0;
            r_virt_part <= '0;
            r_evicted   <= '0;
        end else begin
            case (i_ctrl.op)
                OP_CHECK: begin
                    if (r_size > w_cap_sum) begin
                        r_status <= ST_TOO_LARGE;
                    end else if (r_ram_vld[r_id] || r_virt_vld[r_id]) begin
                        r_status <= ST_HELD;
                    end
                end
                OP_TAKE: begin
                    r_old <= w_fifo_q;
                    if (r_ram_vld[w_fifo_q]) begin
                        r_evicted <= r_evicted + 1'b1;
                    end
                end
                OP_SPLIT: begin
                    r_ram_part  <= w_ram_take;
                    r_virt_part <= r_size - {1'b0, w_ram_take};
                end
                default: begin
                end
            endcase
        end
    end

    // Capacities, usage counters, FIFO pointers and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_cap   <= '0;
            r_virt_cap  <= '0;
            r_ram_used  <= '0;
            r_virt_used <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_ram_vld   <= '0;
            r_virt_vld  <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_RAM_CAP) begin
                    r_ram_cap <= i_cfg_data;
                end else begin
                    r_virt_cap <= i_cfg_data;
                end
            end
            case (i_ctrl.op)
                OP_POP: begin
                    r_head <= r_head + 1'b1;
                    r_fill <= r_fill - 1'b1;
                end
                OP_TAKE: begin
                    r_ram_vld[w_fifo_q] <= 1'b0;
                end
                OP_EVICT: begin
                    r_ram_used         <= w_used_sub;
                    r_virt_used        <= w_vused_new;
                    r_virt_vld[r_old]  <= 1'b1;
                end
                OP_PUT_RAM: begin
                    if (w_place_ram) begin
                        r_ram_vld[r_id] <= 1'b1;
                        r_ram_used      <= r_ram_used + r_ram_part;
                        if (!w_fill_full) begin
                            r_tail <= r_tail + 1'b1;
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                OP_PUT_VIRT: begin
                    if (w_place_virt) begin
                        r_virt_vld[r_id] <= 1'b1;
                        r_virt_used      <= w_vused_new;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result as it stands after the request.
    assign o_result.status             = r_status;
    assign o_result.ram_granted        = r_ram_part;
    assign o_result.virtual_granted    = r_virt_part;
    assign o_result.evicted_count      = r_evicted;
    assign o_result.ram_in_use         = r_ram_used;
    assign o_result.virtual_in_use     = r_virt_used;
    assign o_result.virtual_overcommit = r_virt_used > {2'b00, r_virt_cap};

endmodule
